// ===== rtl/petb_pkg.sv =====
// Package with shared types, constants and helpers of the polygon edge table builder.
`default_nettype none
package petb_pkg;

  localparam int MaxVertices = 16;
  localparam int CoordW      = 32;
  localparam int RowW        = 16;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
  } vertex_t;

  localparam int VertexW = $bits(vertex_t);

  // Round a Q16.16 value to a row, half away from zero, saturated to 16 bits.
  function automatic logic signed [RowW-1:0] round_row(input logic signed [CoordW-1:0] v);
    logic [CoordW:0] mag;
    logic [CoordW:0] sum;
    logic [16:0]     r;
    mag = v[CoordW-1] ? (CoordW+1)'(-{v[CoordW-1], v}) : {1'b0, v};
    sum = mag + (CoordW+1)'(32768);
    r   = sum[CoordW:16];
    if (!v[CoordW-1]) begin
      round_row = (r > 17'd32767) ? 16'sh7fff : r[15:0];
    end else begin
      round_row = RowW'(17'(-r));
    end
  endfunction

endpackage
`default_nettype wire

// ===== rtl/petb_if.sv =====
// Channel interfaces: vertex items in and edge record items out.
`default_nettype none
interface petb_vtx_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] vertex_x;
  logic signed [31:0] vertex_y;
  logic signed [31:0] vertex_z;
  logic               final_vertex;
  modport source (output valid, vertex_x, vertex_y, vertex_z, final_vertex, input ready);
  modport sink   (input valid, vertex_x, vertex_y, vertex_z, final_vertex, output ready);
endinterface

interface petb_rec_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] bucket_row;
  logic signed [15:0] upper_row;
  logic signed [31:0] x_start;
  logic signed [31:0] z_start;
  logic signed [31:0] x_step;
  logic signed [31:0] z_step;
  logic               overflow_flag;
  logic               last_record;
  modport source (output valid, bucket_row, upper_row, x_start, z_start, x_step, z_step,
                  overflow_flag, last_record, input ready);
  modport sink   (input valid, bucket_row, upper_row, x_start, z_start, x_step, z_step,
                  overflow_flag, last_record, output ready);
endinterface
`default_nettype wire

// ===== rtl/polygon_edge_table_build_core.sv =====
// Top level of the polygon edge table builder: vertex store, walk sequencer and record output.
`default_nettype none
// Vertices are taken one per cycle while the block is idle and written into a RAM of
// MAX_VERTICES entries. The final vertex starts a walk over the stored vertices: each vertex
// is read, then its left neighbour, then its right neighbour once the left edge is done. Every
// higher neighbour yields an edge record whose two steps come from one shared bit-serial
// divider, the x step first and then the z step. One record is held back until the next is
// known, so the last one can be marked. Vertex input stays closed from the final vertex until
// the last record is loaded into the output register.
module polygon_edge_table_build_core
  import petb_pkg::*;
#(
  parameter int MAX_VERTICES = MaxVertices
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  petb_vtx_if.sink   vtx_i,
  petb_rec_if.source rec_o
);
  localparam int IW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StRdLo  = 3'd1;
  localparam logic [2:0] StCapLo = 3'd2;
  localparam logic [2:0] StCapHi = 3'd3;
  localparam logic [2:0] StDivX  = 3'd4;
  localparam logic [2:0] StDivZ  = 3'd5;
  localparam logic [2:0] StPush  = 3'd6;
  localparam logic [2:0] StAdv   = 3'd7;

  logic [2:0]    st_q, st_d;
  logic          flushing_q, flushing_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          drop_q, drop_d;
  logic [CW-1:0] n_q, n_d;
  logic          ovf_q, ovf_d;
  logic [IW-1:0] i_q, i_d;
  logic          side_q, side_d;
  vertex_t       lo_q, hi_q;
  logic signed [31:0] xstep_q;

  logic          full;
  logic          in_acc;
  logic [CW-1:0] nm1;
  logic [IW-1:0] left_idx, right_idx;
  logic          i_is_last;

  logic          ram_we;
  logic [IW-1:0] ram_raddr;
  vertex_t       ram_rdata;
  vertex_t       ram_wdata;

  logic               div_start;
  logic               div_done;
  logic signed [32:0] div_num;
  logic        [32:0] dy;
  logic signed [31:0] div_q;

  // Pending record and output register.
  logic               pend_v_q, pend_v_d;
  logic signed [15:0] p_brow_q, p_urow_q;
  logic signed [31:0] p_x_q, p_z_q, p_xs_q, p_zs_q;
  logic               p_ovf_q;
  logic               load_pend, load_out, out_last;
  logic               out_v_q;
  logic signed [15:0] o_brow_q, o_urow_q;
  logic signed [31:0] o_x_q, o_z_q, o_xs_q, o_zs_q;
  logic               o_ovf_q, o_last_q;

  assign full      = (cnt_q == CW'(MAX_VERTICES));
  assign in_acc    = vtx_i.valid && vtx_i.ready;
  assign nm1       = n_q - CW'(1);
  assign i_is_last = (i_q == nm1[IW-1:0]);
  assign left_idx  = (i_q == '0) ? nm1[IW-1:0] : i_q - IW'(1);
  assign right_idx = i_is_last ? '0 : i_q + IW'(1);

  assign vtx_i.ready = (st_q == StIdle) && !flushing_q;
  assign ram_we      = in_acc && !full;
  assign ram_wdata   = '{x: vtx_i.vertex_x, y: vtx_i.vertex_y, z: vtx_i.vertex_z};

  petb_ram #(.WIDTH(VertexW), .DEPTH(MAX_VERTICES)) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[IW-1:0]),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Differences of the current edge; dy is positive whenever a division runs.
  // The x division starts while the upper vertex is still on the RAM output.
  assign dy      = (st_q == StCapHi)
                 ? ({ram_rdata.y[31], ram_rdata.y} - {lo_q.y[31], lo_q.y})
                 : ({hi_q.y[31], hi_q.y} - {lo_q.y[31], lo_q.y});
  assign div_num = (st_q == StCapHi)
                 ? ({ram_rdata.x[31], ram_rdata.x} - {lo_q.x[31], lo_q.x})
                 : ({hi_q.z[31], hi_q.z} - {lo_q.z[31], lo_q.z});

  petb_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (dy[31:0]),
    .done_o  (div_done),
    .quot_o  (div_q)
  );

  // Walk sequencer.
  always_comb begin
    st_d       = st_q;
    flushing_d = flushing_q;
    cnt_d      = cnt_q;
    drop_d     = drop_q;
    n_d        = n_q;
    ovf_d      = ovf_q;
    i_d        = i_q;
    side_d     = side_q;
    ram_raddr  = i_q;
    div_start  = 1'b0;
    load_pend  = 1'b0;
    load_out   = 1'b0;
    out_last   = 1'b0;
    pend_v_d   = pend_v_q;
    if (flushing_q) begin
      if (!pend_v_q) begin
        flushing_d = 1'b0;
      end else if (!out_v_q) begin
        load_out   = 1'b1;
        out_last   = 1'b1;
        pend_v_d   = 1'b0;
        flushing_d = 1'b0;
      end
    end else begin
      case (st_q)
        StIdle: begin
          if (in_acc) begin
            if (full) begin
              drop_d = 1'b1;
            end else begin
              cnt_d = cnt_q + CW'(1);
            end
            if (vtx_i.final_vertex) begin
              n_d    = full ? cnt_q : cnt_q + CW'(1);
              ovf_d  = drop_q || full;
              cnt_d  = '0;
              drop_d = 1'b0;
              i_d    = '0;
              st_d   = StRdLo;
            end
          end
        end
        StRdLo: begin
          ram_raddr = i_q;
          st_d      = StCapLo;
        end
        StCapLo: begin
          ram_raddr = left_idx;
          side_d    = 1'b0;
          st_d      = StCapHi;
        end
        StCapHi: begin
          if ($signed(ram_rdata.y) > $signed(lo_q.y)) begin
            st_d = StDivX;
          end else begin
            st_d = StAdv;
          end
        end
        StDivX: begin
          // The x division runs here; the z division starts as it finishes.
          if (div_done) begin
            st_d = StDivZ;
          end
        end
        StDivZ: begin
          if (div_done) begin
            st_d = StPush;
          end
        end
        StPush: begin
          if (!pend_v_q || !out_v_q) begin
            load_out  = pend_v_q;
            load_pend = 1'b1;
            pend_v_d  = 1'b1;
            st_d      = StAdv;
          end
        end
        StAdv: begin
          if (!side_q) begin
            side_d    = 1'b1;
            ram_raddr = right_idx;
            st_d      = StCapHi;
          end else begin
            side_d = 1'b0;
            if (i_is_last) begin
              flushing_d = 1'b1;
              st_d       = StIdle;
            end else begin
              i_d  = i_q + IW'(1);
              st_d = StRdLo;
            end
          end
        end
        default: begin
          st_d = StIdle;
        end
      endcase
    end
    // Division launches: x on entry to StDivX, z once x is done.
    if (!flushing_q && st_q == StCapHi && st_d == StDivX) begin
      div_start = 1'b1;
    end
    if (!flushing_q && st_q == StDivX && div_done) begin
      div_start = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= StIdle;
      flushing_q <= 1'b0;
      cnt_q      <= '0;
      drop_q     <= 1'b0;
      n_q        <= '0;
      ovf_q      <= 1'b0;
      i_q        <= '0;
      side_q     <= 1'b0;
      pend_v_q   <= 1'b0;
      out_v_q    <= 1'b0;
    end else begin
      st_q       <= st_d;
      flushing_q <= flushing_d;
      cnt_q      <= cnt_d;
      drop_q     <= drop_d;
      n_q        <= n_d;
      ovf_q      <= ovf_d;
      i_q        <= i_d;
      side_q     <= side_d;
      pend_v_q   <= pend_v_d;
      out_v_q    <= (out_v_q && !rec_o.ready) || load_out;
    end
  end

  // Edge data capture and record registers.
  always_ff @(posedge clk_i) begin
    if (!flushing_q && st_q == StCapLo) begin
      lo_q <= ram_rdata;
    end
    if (!flushing_q && st_q == StCapHi) begin
      hi_q <= ram_rdata;
    end
    if (!flushing_q && st_q == StDivX && div_done) begin
      xstep_q <= div_q;
    end
    if (load_out) begin
      o_brow_q <= p_brow_q;
      o_urow_q <= p_urow_q;
      o_x_q    <= p_x_q;
      o_z_q    <= p_z_q;
      o_xs_q   <= p_xs_q;
      o_zs_q   <= p_zs_q;
      o_ovf_q  <= p_ovf_q;
      o_last_q <= out_last;
    end
    if (load_pend) begin
      p_brow_q <= round_row(lo_q.y);
      p_urow_q <= round_row(hi_q.y);
      p_x_q    <= lo_q.x;
      p_z_q    <= lo_q.z;
      p_xs_q   <= xstep_q;
      p_zs_q   <= div_q;
      p_ovf_q  <= ovf_q;
    end
  end

  assign rec_o.valid         = out_v_q;
  assign rec_o.bucket_row    = o_brow_q;
  assign rec_o.upper_row     = o_urow_q;
  assign rec_o.x_start       = o_x_q;
  assign rec_o.z_start       = o_z_q;
  assign rec_o.x_step        = o_xs_q;
  assign rec_o.z_step        = o_zs_q;
  assign rec_o.overflow_flag = o_ovf_q;
  assign rec_o.last_record   = o_last_q;
endmodule
`default_nettype wire

// ===== rtl/petb_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module petb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== rtl/petb_div.sv =====
// Bit-serial restoring divider for (delta * 65536) / dy with saturation to 32 bits.
`default_nettype none
module petb_div
  import petb_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [32:0] num_i,
  input  wire logic        [31:0] den_i,
  output logic                    done_o,
  output logic signed [31:0]      quot_o
);
  logic [47:0] sh_q, sh_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] den_q;
  logic        neg_q;
  logic        busy_q, busy_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        done_q, done_d;
  logic [32:0] mag_in;
  logic [32:0] rem_sh;

  assign mag_in = num_i[32] ? 33'(-num_i) : num_i;
  assign rem_sh = {rem_q, sh_q[47]};

  // One quotient bit per cycle; dividend bits shift out as quotient bits shift in.
  always_comb begin
    sh_d   = sh_q;
    rem_d  = rem_q;
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      sh_d   = {mag_in[31:0], 16'd0};
      rem_d  = '0;
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, den_q}) begin
        rem_d = 32'(rem_sh - {1'b0, den_q});
        sh_d  = {sh_q[46:0], 1'b1};
      end else begin
        rem_d = rem_sh[31:0];
        sh_d  = {sh_q[46:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd47) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= den_i;
      neg_q <= num_i[32];
    end
  end

  // Apply the sign and clamp to the signed 32-bit range.
  always_comb begin
    if (!neg_q) begin
      quot_o = (sh_q[47:31] != '0) ? 32'sh7fffffff : sh_q[31:0];
    end else if (sh_q[47:32] != '0 || (sh_q[31] && sh_q[30:0] != '0)) begin
      quot_o = 32'sh80000000;
    end else begin
      quot_o = 32'(-sh_q[31:0]);
    end
  end

  assign done_o = done_q;
endmodule
`default_nettype wire

// ===== rtl/petb_checker.sv =====
// Port-level checker for the polygon edge table builder and its bind.
`default_nettype none
module petb_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        in_final_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic        out_last_i,
  input wire logic [31:0] out_x_step_i
);
  // A stalled record item keeps its valid and its x step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_x_step_i))
    else $error("stalled record item changed");

  // A final vertex closes the vertex input for the walk.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_final_i |=> !in_ready_i)
    else $error("vertex input open right after final vertex");

  // Nothing follows the last record of a polygon at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && out_last_i |=> !out_valid_i)
    else $error("record item right after last record");

  // A record that is not last means the walk is still running.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_last_i |=> !in_ready_i)
    else $error("vertex input open before last record");
endmodule

bind polygon_edge_table_build_core petb_checker u_petb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (vtx_i.valid),
  .in_ready_i   (vtx_i.ready),
  .in_final_i   (vtx_i.final_vertex),
  .out_valid_i  (rec_o.valid),
  .out_ready_i  (rec_o.ready),
  .out_last_i   (rec_o.last_record),
  .out_x_step_i (rec_o.x_step)
);
`default_nettype wire

// ===== verif/tb_polygon_edge_table_build_core.sv =====
// Testbench of the polygon edge table builder: vertex stimulus, edge record prediction and check.
`default_nettype none
module tb_polygon_edge_table_build_core
  import petb_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               fin;
  } vertex_item_t;

  typedef struct {
    logic signed [15:0] bucket_row;
    logic signed [15:0] upper_row;
    logic signed [31:0] x_start;
    logic signed [31:0] z_start;
    logic signed [31:0] x_step;
    logic signed [31:0] z_step;
    logic               overflow_flag;
    logic               last_record;
  } edge_rec_t;

  typedef enum int {
    IdleNone,
    IdleSender,
    IdleReceiver,
    IdleBoth
  } idle_mode_e;

  logic clk_i;
  logic rst_ni;

  petb_vtx_if vtx ();
  petb_rec_if rec ();

  polygon_edge_table_build_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vtx_i  (vtx),
    .rec_o  (rec)
  );

  vertex_item_t pending_vertices[$];
  edge_rec_t    expected_records[$];
  vertex_item_t cur_vertex;
  idle_mode_e   idle_mode;
  int           mismatches;
  int           items_queued;
  int           hold_left;
  logic         hold_start;

  // Predictor state: the vertices of the polygon being loaded.
  vertex_t     poly_store[MaxVertices];
  int unsigned poly_count;
  logic        poly_dropped;

  // Clock generation.
  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Round a Q16.16 value to a row, half away from zero, saturated high.
  function automatic logic signed [15:0] row_of(input logic signed [31:0] v);
    longint w;
    longint r;
    w = v;
    if (w >= 0) r = (w + 32768) / 65536;
    else r = -((-w + 32768) / 65536);
    if (r > 32767) r = 32767;
    return r[15:0];
  endfunction

  // Per-row step, truncating toward zero and saturated to 32 bits.
  function automatic logic signed [31:0] step_of(input longint num, input longint den);
    longint q;
    q = (num * 65536) / den;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q[31:0];
  endfunction

  function automatic edge_rec_t make_edge(input vertex_t lo, input vertex_t hi);
    edge_rec_t r;
    longint    dy;
    dy = longint'(hi.y) - longint'(lo.y);
    r.bucket_row    = row_of(lo.y);
    r.upper_row     = row_of(hi.y);
    r.x_start       = lo.x;
    r.z_start       = lo.z;
    r.x_step        = step_of(longint'(hi.x) - longint'(lo.x), dy);
    r.z_step        = step_of(longint'(hi.z) - longint'(lo.z), dy);
    r.overflow_flag = poly_dropped;
    r.last_record   = 1'b0;
    return r;
  endfunction

  // Store one accepted vertex; on the final one, walk the polygon and queue its edges.
  task automatic load_vertex(input vertex_item_t v);
    int        n;
    int        lft;
    int        rgt;
    int        made;
    edge_rec_t recs[$];
    if (poly_count < MaxVertices) begin
      poly_store[poly_count] = '{x: v.x, y: v.y, z: v.z};
      poly_count++;
    end else begin
      poly_dropped = 1'b1;
    end
    if (!v.fin) return;
    n = poly_count;
    made = 0;
    for (int i = 0; i < n; i++) begin
      lft = (i == 0) ? n - 1 : i - 1;
      rgt = (i == n - 1) ? 0 : i + 1;
      if (poly_store[lft].y > poly_store[i].y && made < 32) begin
        recs.insert(recs.size(), make_edge(poly_store[i], poly_store[lft]));
        made++;
      end
      if (poly_store[rgt].y > poly_store[i].y && made < 32) begin
        recs.insert(recs.size(), make_edge(poly_store[i], poly_store[rgt]));
        made++;
      end
    end
    if (made > 0) recs[made-1].last_record = 1'b1;
    foreach (recs[k]) expected_records.insert(expected_records.size(), recs[k]);
    poly_count = 0;
    poly_dropped = 1'b0;
  endtask

  // Vertex driver: holds an item until it is taken, then offers the next one.
  always @(posedge clk_i) begin
    logic sender_gap;
    if (rst_ni) begin
      if (vtx.valid && vtx.ready) load_vertex(cur_vertex);
      if (!vtx.valid || vtx.ready) begin
        sender_gap = (idle_mode == IdleSender && $urandom_range(99) < 83) ||
                     (idle_mode == IdleBoth && $urandom_range(99) < 9);
        if (pending_vertices.size() != 0 && !sender_gap) begin
          cur_vertex = pending_vertices.pop_front();
          vtx.valid        <= 1'b1;
          vtx.vertex_x     <= cur_vertex.x;
          vtx.vertex_y     <= cur_vertex.y;
          vtx.vertex_z     <= cur_vertex.z;
          vtx.final_vertex <= cur_vertex.fin;
        end else begin
          vtx.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here in cycles.
  always @(posedge clk_i) begin
    if (hold_start) hold_left <= 3000;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // Receiver ready, with random stalls per idling phase.
  always @(posedge clk_i) begin
    logic stall;
    if (rst_ni) begin
      stall = (idle_mode == IdleReceiver && $urandom_range(99) < 83) ||
              (idle_mode == IdleBoth && $urandom_range(99) < 9) ||
              hold_start || hold_left > 1;
      rec.ready <= !stall;
    end
  end

  // Record monitor: compare each taken record with the oldest expected one.
  always @(posedge clk_i) begin
    edge_rec_t want;
    if (rst_ni && rec.valid && rec.ready) begin
      if (expected_records.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected edge record: row %0d..%0d", rec.bucket_row, rec.upper_row);
      end else begin
        want = expected_records.pop_front();
        if (rec.bucket_row !== want.bucket_row || rec.upper_row !== want.upper_row ||
            rec.x_start !== want.x_start || rec.z_start !== want.z_start ||
            rec.x_step !== want.x_step || rec.z_step !== want.z_step ||
            rec.overflow_flag !== want.overflow_flag ||
            rec.last_record !== want.last_record) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Edge record mismatch:");
            $display("  expected rows %0d %0d x %h z %h dx %h dz %h ovf %b last %b",
                     want.bucket_row, want.upper_row, want.x_start, want.z_start,
                     want.x_step, want.z_step, want.overflow_flag, want.last_record);
            $display("  actual   rows %0d %0d x %h z %h dx %h dz %h ovf %b last %b",
                     rec.bucket_row, rec.upper_row, rec.x_start, rec.z_start,
                     rec.x_step, rec.z_step, rec.overflow_flag, rec.last_record);
          end
        end
      end
    end
  end

  task automatic add_vertex(input logic signed [31:0] x, input logic signed [31:0] y,
                            input logic signed [31:0] z, input logic fin);
    pending_vertices.insert(pending_vertices.size(), '{x: x, y: y, z: z, fin: fin});
    items_queued++;
  endtask

  // Coordinate within 20 rows of zero, or anywhere in the full range.
  function automatic logic signed [31:0] rand_coord(input bit wide);
    if (wide) return $urandom;
    return $signed($urandom_range(40 * 65536)) - 20 * 65536;
  endfunction

  // One random polygon; most are well-formed, some are degenerate or overflow the store.
  task automatic add_polygon();
    int   n;
    int   kind;
    bit   wide;
    logic signed [31:0] y;
    kind = $urandom_range(99);
    if (kind < 8) n = $urandom_range(19, 17);
    else if (kind < 14) n = $urandom_range(2, 1);
    else n = $urandom_range(10, 3);
    wide = ($urandom_range(3) == 0);
    y = rand_coord(wide);
    for (int i = 0; i < n; i++) begin
      // Repeat the previous y now and then to make horizontal edges.
      if ($urandom_range(4) != 0) y = rand_coord(wide);
      add_vertex(rand_coord(wide), y, rand_coord(wide), i == n - 1);
    end
  endtask

  task automatic wait_drained();
    while (pending_vertices.size() != 0 || vtx.valid || expected_records.size() != 0)
      @(posedge clk_i);
  endtask

  // Stimulus and end of run.
  initial begin
    vtx.valid = 1'b0;
    vtx.vertex_x = '0;
    vtx.vertex_y = '0;
    vtx.vertex_z = '0;
    vtx.final_vertex = 1'b0;
    rec.ready = 1'b0;
    hold_start = 1'b0;
    hold_left = 0;
    mismatches = 0;
    items_queued = 0;
    poly_count = 0;
    poly_dropped = 1'b0;
    idle_mode = IdleNone;
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: plain triangle.
    add_vertex(32'sh0000_0000, 32'sh0000_0000, 32'sh0001_0000, 1'b0);
    add_vertex(32'sh000a_0000, 32'sh0005_0000, 32'sh0000_0000, 1'b0);
    add_vertex(32'shfff6_0000, 32'sh000a_8000, 32'sh0003_0000, 1'b1);
    // All vertices on one row: no edges.
    add_vertex(32'sh0001_0000, 32'sh0002_0000, 32'sh0, 1'b0);
    add_vertex(32'sh0005_0000, 32'sh0002_0000, 32'sh0, 1'b0);
    add_vertex(32'sh0009_0000, 32'sh0002_0000, 32'sh0, 1'b1);
    // Extremes: saturated rows and steps, half-row rounding both signs.
    add_vertex(32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, 1'b0);
    add_vertex(32'sh7fff_ffff, 32'sh8000_0001, 32'sh8000_0000, 1'b0);
    add_vertex(32'sh0000_0000, 32'sh7fff_ffff, 32'sh0000_0000, 1'b1);
    add_vertex(32'sh0000_1234, 32'shffff_8000, 32'sh0000_0000, 1'b0);
    add_vertex(32'sh0000_0000, 32'sh0000_8000, 32'shffff_ffff, 1'b0);
    add_vertex(32'sh0000_0000, 32'sh0000_7fff, 32'sh0000_0001, 1'b1);
    // Store full: the final vertex itself is dropped.
    for (int i = 0; i < 17; i++)
      add_vertex(i * 32'sh0001_0000, ((i * 7) % 5) * 32'sh0001_0000, -i, i == 16);
    wait_drained();

    for (int ph = IdleNone; ph <= IdleBoth; ph++) begin
      idle_mode = idle_mode_e'(ph);
      while (items_queued < 29 + (ph + 1) * 100) add_polygon();
      // Long receiver hold-off while vertices keep coming.
      if (ph == IdleNone) begin
        @(posedge clk_i);
        hold_start <= 1'b1;
        @(posedge clk_i);
        hold_start <= 1'b0;
      end
      wait_drained();
    end

    repeat (300) @(posedge clk_i);
    if (mismatches == 0 && expected_records.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Timeout.
  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
`default_nettype wire
